// ===== rtl/core/otpa_pkg.sv =====
package otpa_pkg;

	localparam int MAX_PAGES_DEF = 1024;
	localparam int PAGE_BYTES_LOG2_DEF = 12;
	localparam logic [31:0] SYS_OWNER = 32'hFFFF_FFFF;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_RAM_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 2'd2;

	typedef enum logic [1:0] {
		OP_INIT = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE = 2'd2,
		OP_COUNT = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_NOINIT = 3'd1,
		ST_NOPAGE = 3'd2,
		ST_BADCOUNT = 3'd3,
		ST_BADOWNER = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INIT,
		S_ALLOC_RD,
		S_ALLOC_WR,
		S_FREE,
		S_FREE_END,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t opcode;
		logic [31:0] owner_id;
		logic [3:0] request_count;
	} in_t;

	typedef struct packed {
		status_t status;
		logic [9:0] page_index;
		logic [31:0] page_address;
		logic [10:0] freed_now;
		logic [10:0] pages_held;
		logic [10:0] peak_pages;
		logic [31:0] freed_total;
		logic [31:0] proc_total;
	} out_t;

	typedef struct packed {
		logic latch;
		logic init_step;
		logic alloc_wr;
		logic free_step;
		logic free_end;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic initialized;
		logic pre_ok;
		logic scan_end;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/core/owner_tagged_page_allocator_top.sv =====
// Owner-tagged page frame allocator.
// Input channel in_valid/in_ready/in_data carries one operation: init, allocate,
// free all pages of an owner, or count a process. Every operation produces exactly
// one result transfer on out_valid/out_ready/out_data with status and statistics.
// Configuration (ram_base, pages_in_use, reserved_pages) is written through
// cfg_we/cfg_index/cfg_data by the user only while the block is idle (the block
// does not enforce this); it takes effect at init. One item is handled at a time;
// in_ready is high only when the sequencer is idle. Steps from input to result:
//   count process, error results, repeated init: straight to the result
//   allocate: one link table read, then one table write
//   init: one table entry written per cycle up to pages_in_use
//   free: owner table scanned one entry per cycle, with the compare and relink
//   in the cycle after the read
// The page tables are memories with a single write port; init and free walk them.
// After reset the allocator is uninitialized and all counters are zero; the
// tables are not cleared and are written by init before any use.
// A stalled receiver holds the result in the output register; the block finishes
// the next item up to its result and then waits for the register to drain.
module owner_tagged_page_allocator_top #(
	parameter int MAX_PAGES = otpa_pkg::MAX_PAGES_DEF,
	parameter int PAGE_BYTES_LOG2 = otpa_pkg::PAGE_BYTES_LOG2_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [otpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [otpa_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input otpa_pkg::in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output otpa_pkg::out_t out_data
);

	otpa_pkg::cmd_t cmd;
	otpa_pkg::sts_t sts;

	otpa_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(in_data.opcode),
		.sts(sts),
		.cmd(cmd)
	);

	otpa_dp #(
		.MAX_PAGES(MAX_PAGES),
		.PAGE_BYTES_LOG2(PAGE_BYTES_LOG2)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cmd(cmd),
		.sts(sts)
	);

endmodule

// ===== rtl/core/otpa_ram.sv =====
module otpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/otpa_ctrl.sv =====
module otpa_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input otpa_pkg::op_t opcode,
	input otpa_pkg::sts_t sts,
	output otpa_pkg::cmd_t cmd
);

	otpa_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= otpa_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			otpa_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					if (!sts.pre_ok) begin
						state_nx = otpa_pkg::S_DONE;
					end else begin
						case (opcode)
							otpa_pkg::OP_INIT: state_nx = sts.initialized ?
								otpa_pkg::S_DONE : otpa_pkg::S_INIT;
							otpa_pkg::OP_ALLOC: state_nx = otpa_pkg::S_ALLOC_RD;
							otpa_pkg::OP_FREE: state_nx = otpa_pkg::S_FREE;
							default: state_nx = otpa_pkg::S_DONE;
						endcase
					end
				end
			end
			otpa_pkg::S_INIT: begin
				if (sts.scan_end) begin
					state_nx = otpa_pkg::S_DONE;
				end else begin
					cmd.init_step = 1'b1;
				end
			end
			otpa_pkg::S_ALLOC_RD: state_nx = otpa_pkg::S_ALLOC_WR;
			otpa_pkg::S_ALLOC_WR: begin
				cmd.alloc_wr = 1'b1;
				state_nx = otpa_pkg::S_DONE;
			end
			otpa_pkg::S_FREE: begin
				cmd.free_step = 1'b1;
				if (sts.scan_end) begin
					state_nx = otpa_pkg::S_FREE_END;
				end
			end
			otpa_pkg::S_FREE_END: begin
				cmd.free_end = 1'b1;
				state_nx = otpa_pkg::S_DONE;
			end
			otpa_pkg::S_DONE: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_nx = otpa_pkg::S_IDLE;
				end
			end
			default: state_nx = otpa_pkg::S_IDLE;
		endcase
	end

endmodule

// ===== rtl/core/otpa_dp.sv =====
module otpa_dp #(
	parameter int MAX_PAGES = otpa_pkg::MAX_PAGES_DEF,
	parameter int PAGE_BYTES_LOG2 = otpa_pkg::PAGE_BYTES_LOG2_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [otpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [otpa_pkg::CFG_DATA_W-1:0] cfg_data,
	input otpa_pkg::in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output otpa_pkg::out_t out_data,
	input otpa_pkg::cmd_t cmd,
	output otpa_pkg::sts_t sts
);

	localparam int IW = $clog2(MAX_PAGES);
	localparam int CW = $clog2(MAX_PAGES + 1);

	logic [31:0] base_q;
	logic [10:0] pages_q, resv_q;

	logic [CW-1:0] n_c, r_c;
	logic [CW-1:0] live_q, r_q, idx_q, alloc_q, peak_q, fnow_q;
	logic [31:0] lbase_q, freedt_q, proc_q, owner_q, paddr_q;
	logic [IW-1:0] head_q, pidx_q, pidx_s1;
	logic hvalid_q, init_q, pend_s1, out_valid_q;
	otpa_pkg::op_t op_q;
	otpa_pkg::status_t stat_q, pre_status;

	logic own_we, lnk_we;
	logic [IW-1:0] own_waddr, lnk_waddr;
	logic [31:0] own_wdata, own_rdata;
	logic [IW:0] lnk_wdata, lnk_rdata;
	logic hit;
	logic [CW:0] idx_nx;
	logic [CW-1:0] alloc_nx;
	logic [32:0] fsum;
	logic bad_owner;

	always_comb begin
		if (32'(pages_q) > 32'(MAX_PAGES)) begin
			n_c = CW'(MAX_PAGES);
		end else begin
			n_c = CW'(pages_q);
		end
		if (32'(resv_q) > 32'(n_c)) begin
			r_c = n_c;
		end else begin
			r_c = CW'(resv_q);
		end
	end

	assign bad_owner = (in_data.owner_id == 32'd0) || (in_data.owner_id == otpa_pkg::SYS_OWNER);

	always_comb begin
		pre_status = otpa_pkg::ST_OK;
		case (in_data.opcode)
			otpa_pkg::OP_ALLOC: begin
				if (!init_q) pre_status = otpa_pkg::ST_NOINIT;
				else if (in_data.request_count != 4'd1) pre_status = otpa_pkg::ST_BADCOUNT;
				else if (bad_owner) pre_status = otpa_pkg::ST_BADOWNER;
				else if (!hvalid_q) pre_status = otpa_pkg::ST_NOPAGE;
			end
			otpa_pkg::OP_FREE: begin
				if (!init_q) pre_status = otpa_pkg::ST_NOINIT;
				else if (bad_owner) pre_status = otpa_pkg::ST_BADOWNER;
			end
			default: pre_status = otpa_pkg::ST_OK;
		endcase
	end

	assign idx_nx = {1'b0, idx_q} + 1'b1;
	assign hit = pend_s1 && (own_rdata == owner_q);
	assign alloc_nx = alloc_q + 1'b1;
	assign fsum = {1'b0, freedt_q} + 33'(fnow_q);

	always_comb begin
		own_we = 1'b0;
		lnk_we = 1'b0;
		own_waddr = idx_q[IW-1:0];
		lnk_waddr = idx_q[IW-1:0];
		own_wdata = 32'd0;
		lnk_wdata = '0;
		if (cmd.init_step) begin
			own_we = 1'b1;
			lnk_we = 1'b1;
			own_wdata = (idx_q < r_q) ? otpa_pkg::SYS_OWNER : 32'd0;
			if (idx_q >= r_q && idx_nx < {1'b0, live_q}) begin
				lnk_wdata = {1'b1, idx_nx[IW-1:0]};
			end
		end else if (cmd.alloc_wr) begin
			own_we = 1'b1;
			lnk_we = 1'b1;
			own_waddr = head_q;
			lnk_waddr = head_q;
			own_wdata = owner_q;
		end else if (hit) begin
			own_we = 1'b1;
			lnk_we = 1'b1;
			own_waddr = pidx_s1;
			lnk_waddr = pidx_s1;
			lnk_wdata = {hvalid_q, head_q};
		end
	end

	otpa_ram #(.WIDTH(32), .DEPTH(MAX_PAGES)) u_own (
		.clk(clk), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
		.raddr(idx_q[IW-1:0]), .rdata(own_rdata)
	);

	otpa_ram #(.WIDTH(IW + 1), .DEPTH(MAX_PAGES)) u_lnk (
		.clk(clk), .we(lnk_we), .waddr(lnk_waddr), .wdata(lnk_wdata),
		.raddr(head_q), .rdata(lnk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 32'd0;
			pages_q <= 11'd1024;
			resv_q <= 11'd1;
			live_q <= '0;
			r_q <= '0;
			idx_q <= '0;
			alloc_q <= '0;
			peak_q <= '0;
			fnow_q <= '0;
			lbase_q <= 32'd0;
			freedt_q <= 32'd0;
			proc_q <= 32'd0;
			head_q <= '0;
			hvalid_q <= 1'b0;
			init_q <= 1'b0;
			pend_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					otpa_pkg::CFG_RAM_BASE: base_q <= cfg_data;
					otpa_pkg::CFG_PAGES: pages_q <= cfg_data[10:0];
					otpa_pkg::CFG_RESERVED: resv_q <= cfg_data[10:0];
					default: ;
				endcase
			end
			pend_s1 <= cmd.free_step && (idx_q != live_q);
			if (cmd.latch) begin
				idx_q <= '0;
				fnow_q <= '0;
				if (in_data.opcode == otpa_pkg::OP_COUNT && proc_q != 32'hFFFF_FFFF) begin
					proc_q <= proc_q + 32'd1;
				end
				if (in_data.opcode == otpa_pkg::OP_INIT && !init_q) begin
					init_q <= 1'b1;
					live_q <= n_c;
					r_q <= r_c;
					lbase_q <= base_q;
					alloc_q <= r_c;
					peak_q <= r_c;
					freedt_q <= 32'd0;
					proc_q <= 32'd0;
					hvalid_q <= (r_c < n_c);
					head_q <= r_c[IW-1:0];
				end
			end
			if (cmd.init_step || (cmd.free_step && idx_q != live_q)) begin
				idx_q <= idx_nx[CW-1:0];
			end
			if (cmd.alloc_wr) begin
				hvalid_q <= lnk_rdata[IW];
				head_q <= lnk_rdata[IW-1:0];
				alloc_q <= alloc_nx;
				if (alloc_nx > peak_q) begin
					peak_q <= alloc_nx;
				end
			end
			if (hit) begin
				head_q <= pidx_s1;
				hvalid_q <= 1'b1;
				fnow_q <= fnow_q + 1'b1;
			end
			if (cmd.free_end) begin
				alloc_q <= (alloc_q >= fnow_q) ? alloc_q - fnow_q : '0;
				freedt_q <= fsum[32] ? 32'hFFFF_FFFF : fsum[31:0];
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pidx_s1 <= idx_q[IW-1:0];
		if (cmd.latch) begin
			op_q <= in_data.opcode;
			owner_q <= in_data.owner_id;
			stat_q <= pre_status;
			pidx_q <= '0;
			paddr_q <= 32'd0;
		end
		if (cmd.alloc_wr) begin
			pidx_q <= head_q;
			paddr_q <= lbase_q + (32'(head_q) << PAGE_BYTES_LOG2);
		end
		if (cmd.load) begin
			out_data.status <= stat_q;
			out_data.page_index <= 10'(pidx_q);
			out_data.page_address <= paddr_q;
			out_data.freed_now <= (op_q == otpa_pkg::OP_FREE) ? 11'(fnow_q) : 11'd0;
			out_data.pages_held <= 11'(alloc_q);
			out_data.peak_pages <= 11'(peak_q);
			out_data.freed_total <= freedt_q;
			out_data.proc_total <= proc_q;
		end
	end

	assign out_valid = out_valid_q;
	assign sts.initialized = init_q;
	assign sts.pre_ok = (pre_status == otpa_pkg::ST_OK);
	assign sts.scan_end = (idx_q == live_q) && !pend_s1;
	assign sts.out_free = !out_valid_q || out_ready;

endmodule
